@@ rtl/aes_pkg.sv @@
`default_nettype none
package aes_pkg;

  localparam int KeySlots = 15;
  localparam int SlotW = $clog2(KeySlots);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [1:0] REG_KEY_LENGTH_MODE = 2'd0;

  // controller -> datapath
  typedef struct packed {
    logic       load_blk;   // take the input block and mark direction
    logic       rd_en;      // read round key slot
    logic [3:0] rd_slot;
    logic       do_init;    // state ^= key
    logic       do_round;   // one round with key
    logic       last;       // final round, no mix
    logic       out_load;   // move state to output register
  } dp_cmd_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

endpackage
`default_nettype wire

@@ rtl/aes_block_cipher_core.sv @@
// AES-128/192/256 block cipher, one round per cycle.
// Words, key loads included, are accepted only while the shared round unit is idle;
// it moves each result to the output register before the next word is taken.
// A new word is taken while a finished result waits in the output register.
// Synchronous active-low reset clears control and key_length_mode; key slots undefined.
`default_nettype none
module aes_block_cipher_core
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [1:0]   in_tuser,   // operation
  input  wire logic [135:0] in_tdata,   // key_slot[3:0], word_high[67:4], word_low[131:68]
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic         out_tuser,  // was_decrypt
  output      logic [127:0] out_tdata,  // block_high[63:0], block_low[127:64]
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output      logic [31:0]  cfg_prdata,
  output      logic         cfg_pready
);
  logic [1:0]   mode_r;
  logic         busy;
  logic         in_fire;
  logic         ov;
  logic [127:0] blk, word;
  dp_cmd_t      cmd;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[1:0] == {REG_KEY_LENGTH_MODE[1:0]}) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == REG_KEY_LENGTH_MODE) ? {30'd0, mode_r} : 32'd0;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign word      = {in_tdata[67:4], in_tdata[131:68]};

  aes_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_op           (in_tuser),
    .key_length_mode (mode_r),
    .out_busy        (ov && !out_tready),
    .busy            (busy),
    .cmd             (cmd)
  );

  aes_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_we    (in_fire && in_tuser == OP_LOAD),
    .key_slot  (in_tdata[3:0]),
    .in_word   (word),
    .out_valid (ov),
    .out_ready (out_tready),
    .out_block (blk),
    .out_dec   (out_tuser)
  );

  assign out_tvalid = ov;
  assign out_tdata  = {blk[63:0], blk[127:64]};
endmodule
`default_nettype wire

@@ rtl/aes_ram.sv @@
`default_nettype none
module aes_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/aes_ctrl.sv @@
`default_nettype none
module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] in_op,
  input  wire logic [1:0] key_length_mode,
  input  wire logic       out_busy,
  output      logic       busy,
  output      dp_cmd_t    cmd
);
  state_t     state_r, state_nxt;
  logic       dec_r, dec_nxt;
  logic [3:0] cnt_r, cnt_nxt;   // rounds left
  logic [3:0] slot_r, slot_nxt; // next slot to read
  logic [3:0] nr;
  logic       start;

  assign nr = (key_length_mode == 2'd0) ? 4'd10 : (key_length_mode == 2'd1) ? 4'd12 : 4'd14;
  assign start = in_fire && (in_op == OP_ENCRYPT || in_op == OP_DECRYPT);
  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dec_r   <= 1'b0;
      cnt_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dec_r   <= dec_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    dec_nxt   = dec_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_INIT;
          dec_nxt   = (in_op == OP_DECRYPT);
          cnt_nxt   = nr;
          slot_nxt  = (in_op == OP_DECRYPT) ? nr - 4'd1 : 4'd1;
        end
      end
      ST_INIT: begin
        state_nxt = ST_ROUND;
        slot_nxt  = dec_r ? slot_r - 4'd1 : slot_r + 4'd1;
      end
      ST_ROUND: begin
        cnt_nxt  = cnt_r - 4'd1;
        slot_nxt = dec_r ? slot_r - 4'd1 : slot_r + 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_blk = start;
        cmd.rd_en    = start;
        cmd.rd_slot  = (in_op == OP_DECRYPT) ? nr : 4'd0;
      end
      ST_INIT: begin
        cmd.do_init = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_slot = slot_r;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        cmd.last     = (cnt_r == 4'd1);
        cmd.rd_en    = (cnt_r != 4'd1);
        cmd.rd_slot  = slot_r;
      end
      ST_DONE: cmd.out_load = !out_busy;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/aes_datapath.sv @@
`default_nettype none
module aes_datapath
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dp_cmd_t      cmd,
  input  wire logic         key_we,
  input  wire logic [3:0]   key_slot,
  input  wire logic [127:0] in_word,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output      logic [127:0] out_block,
  output      logic         out_dec
);
  logic [127:0] st_r, st_nxt;
  logic         dec_r;
  logic         ov_r;
  logic [127:0] ob_r;
  logic         od_r;
  logic [127:0] rk;
  logic [127:0] rk_raw;
  logic         oob_r;
  logic         wr_ok;

  assign wr_ok = key_we && (key_slot < 4'(KeySlots));

  aes_ram #(.Width(128), .Depth(KeySlots)) u_keys (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (key_slot[SlotW-1:0]),
    .wdata (in_word),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_slot[SlotW-1:0]),
    .rdata (rk_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      oob_r <= (cmd.rd_slot >= 4'(KeySlots));
    end
  end
  assign rk = oob_r ? '0 : rk_raw;

  // byte i of AES state is bits [127-8i -: 8]
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    gb = s[127-8*i -: 8];
  endfunction

  logic [127:0] ss, mx;
  always_comb begin
    logic [7:0] a0, a1, a2, a3, e, b, d, x2, x4, x8;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; e = '0;
    b = '0; d = '0; x2 = '0; x4 = '0; x8 = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_r) begin
          ss[127-8*(r+4*c) -: 8] = inv_sbox(gb(st_r, r + 4*((c - r + 4) & 3)));
        end else begin
          ss[127-8*(r+4*c) -: 8] = sbox(gb(st_r, r + 4*((c + r) & 3)));
        end
      end
    end
    // forward: mix then key; inverse: key then mix
    st_nxt = dec_r ? (ss ^ rk) : ss;
    for (int c = 0; c < 4; c++) begin
      a0 = gb(st_nxt, 4*c); a1 = gb(st_nxt, 4*c+1);
      a2 = gb(st_nxt, 4*c+2); a3 = gb(st_nxt, 4*c+3);
      if (!dec_r) begin
        e = a0 ^ a1 ^ a2 ^ a3;
        mx[127-8*(4*c) -: 8]   = a0 ^ e ^ xt(a0 ^ a1);
        mx[127-8*(4*c+1) -: 8] = a1 ^ e ^ xt(a1 ^ a2);
        mx[127-8*(4*c+2) -: 8] = a2 ^ e ^ xt(a2 ^ a3);
        mx[127-8*(4*c+3) -: 8] = a3 ^ e ^ xt(a3 ^ a0);
      end else begin
        // inverse mix = preprocess then forward mix
        x4 = xt(xt(a0 ^ a2));
        x8 = xt(xt(a1 ^ a3));
        b = a0 ^ x4; d = a1 ^ x8; x2 = a2 ^ x4; e = a3 ^ x8;
        a0 = b; a1 = d; a2 = x2; a3 = e;
        e = a0 ^ a1 ^ a2 ^ a3;
        mx[127-8*(4*c) -: 8]   = a0 ^ e ^ xt(a0 ^ a1);
        mx[127-8*(4*c+1) -: 8] = a1 ^ e ^ xt(a1 ^ a2);
        mx[127-8*(4*c+2) -: 8] = a2 ^ e ^ xt(a2 ^ a3);
        mx[127-8*(4*c+3) -: 8] = a3 ^ e ^ xt(a3 ^ a0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_blk) begin
      st_r <= in_word;
    end
    if (cmd.do_init) begin
      st_r <= st_r ^ rk;
    end else if (cmd.do_round) begin
      if (cmd.last) begin
        st_r <= dec_r ? st_nxt : (ss ^ rk);
      end else begin
        st_r <= dec_r ? mx : (mx ^ rk);
      end
    end
    if (cmd.out_load) begin
      ob_r <= st_r;
      od_r <= dec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  // direction flag rides with the block; set from the controller's decode
  logic dec_in;
  assign dec_in = cmd.load_blk && cmd.rd_slot != 4'd0;
  always_ff @(posedge clk) begin
    if (cmd.load_blk) begin
      dec_r <= dec_in;
    end
  end

  assign out_valid = ov_r;
  assign out_block = ob_r;
  assign out_dec   = od_r;
endmodule
`default_nettype wire
